@@ rtl/core/rbsi_pkg.sv @@
// Shared constants, types and divider step function for the ray/box slab test.
`timescale 1ns / 1ps
package rbsi_pkg;

  localparam int FRAC_BITS      = 16;
  localparam int DATA_W         = 32;
  localparam int NUM_W          = DATA_W + 1;
  localparam int DVD_W          = NUM_W + FRAC_BITS;
  localparam int REM_W          = DATA_W + 1;
  localparam int BITS_PER_STAGE = 2;
  localparam int DIV_STAGES     = DATA_W / BITS_PER_STAGE;
  localparam int DIV_LAT        = DIV_STAGES + 3;
  localparam int PIPE_LAT       = DIV_LAT + 4;
  localparam int NUM_AXES       = 3;
  localparam int ADDR_W         = 5;

  localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [2:0] {
    REG_MIN_X = 3'd0,
    REG_MIN_Y = 3'd1,
    REG_MIN_Z = 3'd2,
    REG_MAX_X = 3'd3,
    REG_MAX_Y = 3'd4,
    REG_MAX_Z = 3'd5
  } reg_idx_e;

  typedef logic signed [DATA_W-1:0] fx_t;

  typedef struct packed {
    logic dir_zero;
    logic in_slab;
  } axis_flags_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [DATA_W-1:0] dq;
  } div_state_t;

  // One restoring division step: shift in the next dividend bit, subtract if it fits.
  function automatic div_state_t div_step(div_state_t s, logic [DATA_W-1:0] ad);
    div_state_t       n;
    logic [REM_W-1:0] r;
    r    = {s.rem[REM_W-2:0], s.dq[DATA_W-1]};
    n.dq = {s.dq[DATA_W-2:0], 1'b0};
    if (r >= {1'b0, ad}) begin
      r       = r - {1'b0, ad};
      n.dq[0] = 1'b1;
    end
    n.rem = r;
    return n;
  endfunction

endpackage

@@ rtl/core/rbsi_div.sv @@
// Pipelined fixed-point divider with truncation toward zero and 32-bit saturation.
`timescale 1ns / 1ps
module rbsi_div import rbsi_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic signed [NUM_W-1:0] num_i,
  input  fx_t                     den_i,
  output logic                    valid_o,
  output fx_t                     quot_o
);

  // Stage a: magnitudes and result sign.
  logic              va_q;
  logic [NUM_W-1:0]  an_q;
  logic [DATA_W-1:0] ad_q;
  logic              nega_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    an_q   <= num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
    ad_q   <= den_i[DATA_W-1] ? DATA_W'(-den_i) : DATA_W'(den_i);
    nega_q <= num_i[NUM_W-1] ^ den_i[DATA_W-1];
  end

  // Stage b: overflow check and initial partial remainder.
  logic [DVD_W-1:0] dvd;
  assign dvd = {an_q, {FRAC_BITS{1'b0}}};

  logic              v_q   [DIV_STAGES+1];
  logic              neg_q [DIV_STAGES+1];
  logic              ovf_q [DIV_STAGES+1];
  logic [DATA_W-1:0] den_q [DIV_STAGES+1];
  div_state_t        st_q  [DIV_STAGES+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q[0]     <= nega_q;
    ovf_q[0]     <= (an_q >> (DATA_W - 1 - FRAC_BITS)) >= {1'b0, ad_q};
    den_q[0]     <= ad_q;
    st_q[0].rem  <= REM_W'(dvd >> DATA_W);
    st_q[0].dq   <= dvd[DATA_W-1:0];
  end

  // Quotient stages, two bits each.
  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_stage
    div_state_t st_d;

    always_comb begin
      st_d = st_q[k-1];
      for (int b = 0; b < BITS_PER_STAGE; b++) begin
        st_d = div_step(st_d, den_q[k-1]);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      neg_q[k] <= neg_q[k-1];
      ovf_q[k] <= ovf_q[k-1];
      den_q[k] <= den_q[k-1];
      st_q[k]  <= st_d;
    end
  end

  // Output stage: sign and saturation.
  logic [DATA_W-1:0] q_mag;
  fx_t               quot_d;
  assign q_mag = st_q[DIV_STAGES].dq;

  always_comb begin
    if (ovf_q[DIV_STAGES]) begin
      quot_d = neg_q[DIV_STAGES] ? SAT_MIN : SAT_MAX;
    end else begin
      quot_d = neg_q[DIV_STAGES] ? fx_t'(-q_mag) : fx_t'(q_mag);
    end
  end

  logic vo_q;
  fx_t  quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else begin
      vo_q <= v_q[DIV_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
  end

  assign valid_o = vo_q;
  assign quot_o  = quot_q;

  // A zero numerator over a nonzero denominator always divides to zero.
  a_zero_num: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && num_i == '0 && den_i != '0) |-> ##DIV_LAT (valid_o && quot_o == '0))
    else $error("zero numerator gave a nonzero quotient");

  // Non-negative operands over a nonzero denominator never give a negative quotient.
  a_pos_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && !num_i[NUM_W-1] && !den_i[DATA_W-1] && den_i != '0)
      |-> ##DIV_LAT !quot_o[DATA_W-1])
    else $error("positive operands gave a negative quotient");

endmodule

@@ rtl/core/ray_box_slab_intersect.sv @@
// Top level of the ray versus axis-aligned box slab intersection test.
`timescale 1ns / 1ps
//
//  Channel   | Ports                                 | Transfer when
//  ----------+---------------------------------------+-------------------------------
//  ray in    | start, busy, origin_*_i, dir_*_i      | start high and busy low
//  result    | done_o, hit_o                         | every cycle done_o is high
//  config    | psel, penable, pwrite, paddr, pwdata  | psel, penable, pwrite, pready
//
// One ray is accepted every cycle; busy is tied low. Each ray gives one hit
// result. The six pipelined dividers resolve two quotient bits per stage over
// sixteen stages. Reset clears only the valid bits and the box registers, so
// the first ray may follow reset at once. The receiver cannot stall the
// result, and the pipeline never holds, so no ray is lost or repeated.
module ray_box_slab_intersect import rbsi_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Ray input.
  input  logic              start,
  output logic              busy,
  input  fx_t               origin_x_i,
  input  fx_t               origin_y_i,
  input  fx_t               origin_z_i,
  input  fx_t               dir_x_i,
  input  fx_t               dir_y_i,
  input  fx_t               dir_z_i,
  // Result.
  output logic              done_o,
  output logic              hit_o,
  // Configuration.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  assign busy   = 1'b0;
  assign pready = 1'b1;

  // Box registers. The lower corners sit at indexes 0..2, the upper at 3..5.
  fx_t      box_min_q [NUM_AXES];
  fx_t      box_max_q [NUM_AXES];
  reg_idx_e reg_idx;
  logic     cfg_wr;

  assign reg_idx = reg_idx_e'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        box_min_q[a] <= '0;
        box_max_q[a] <= '0;
      end
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_MIN_X: box_min_q[0] <= pwdata;
        REG_MIN_Y: box_min_q[1] <= pwdata;
        REG_MIN_Z: box_min_q[2] <= pwdata;
        REG_MAX_X: box_max_q[0] <= pwdata;
        REG_MAX_Y: box_max_q[1] <= pwdata;
        REG_MAX_Z: box_max_q[2] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MIN_X: prdata = box_min_q[0];
      REG_MIN_Y: prdata = box_min_q[1];
      REG_MIN_Z: prdata = box_min_q[2];
      REG_MAX_X: prdata = box_max_q[0];
      REG_MAX_Y: prdata = box_max_q[1];
      REG_MAX_Z: prdata = box_max_q[2];
      default:   prdata = '0;
    endcase
  end

  // Stage 1: capture the ray.
  logic accept;
  logic s1_v_q;
  fx_t  s1_org_q [NUM_AXES];
  fx_t  s1_dir_q [NUM_AXES];

  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_org_q[0] <= origin_x_i;
    s1_org_q[1] <= origin_y_i;
    s1_org_q[2] <= origin_z_i;
    s1_dir_q[0] <= dir_x_i;
    s1_dir_q[1] <= dir_y_i;
    s1_dir_q[2] <= dir_z_i;
  end

  // Stage 2: exact 33-bit numerators and the zero-direction slab check.
  logic                    s2_v_q;
  logic signed [NUM_W-1:0] s2_lo_q  [NUM_AXES];
  logic signed [NUM_W-1:0] s2_hi_q  [NUM_AXES];
  fx_t                     s2_dir_q [NUM_AXES];
  axis_flags_t             s2_fl_q  [NUM_AXES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < NUM_AXES; a++) begin
      s2_lo_q[a]  <= NUM_W'(box_min_q[a]) - NUM_W'(s1_org_q[a]);
      s2_hi_q[a]  <= NUM_W'(box_max_q[a]) - NUM_W'(s1_org_q[a]);
      s2_dir_q[a] <= s1_dir_q[a];
      s2_fl_q[a].dir_zero <= (s1_dir_q[a] == '0);
      s2_fl_q[a].in_slab  <= !((s1_org_q[a] < box_min_q[a]) ||
                               (s1_org_q[a] > box_max_q[a]));
    end
  end

  // Six dividers, one per slab plane.
  logic lo_v [NUM_AXES];
  logic hi_v [NUM_AXES];
  fx_t  t_lo [NUM_AXES];
  fx_t  t_hi [NUM_AXES];

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    rbsi_div u_div_lo (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (s2_v_q),
      .num_i   (s2_lo_q[a]),
      .den_i   (s2_dir_q[a]),
      .valid_o (lo_v[a]),
      .quot_o  (t_lo[a])
    );
    rbsi_div u_div_hi (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (s2_v_q),
      .num_i   (s2_hi_q[a]),
      .den_i   (s2_dir_q[a]),
      .valid_o (hi_v[a]),
      .quot_o  (t_hi[a])
    );
  end

  // The axis flags ride alongside the dividers.
  axis_flags_t fl_line_q [DIV_LAT][NUM_AXES];

  always_ff @(posedge clk_i) begin
    fl_line_q[0] <= s2_fl_q;
    for (int k = 1; k < DIV_LAT; k++) begin
      fl_line_q[k] <= fl_line_q[k-1];
    end
  end

  // Stage 3: order each interval; a zero-direction axis spans the whole range.
  logic div_v;
  logic s3_v_q;
  logic s3_ok_q;
  fx_t  s3_n_q [NUM_AXES];
  fx_t  s3_f_q [NUM_AXES];
  logic ok_d;

  assign div_v = lo_v[0] && hi_v[0] && lo_v[1] && hi_v[1] && lo_v[2] && hi_v[2];

  always_comb begin
    ok_d = 1'b1;
    for (int a = 0; a < NUM_AXES; a++) begin
      if (fl_line_q[DIV_LAT-1][a].dir_zero && !fl_line_q[DIV_LAT-1][a].in_slab) begin
        ok_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else begin
      s3_v_q <= div_v;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_ok_q <= ok_d;
    for (int a = 0; a < NUM_AXES; a++) begin
      if (fl_line_q[DIV_LAT-1][a].dir_zero) begin
        s3_n_q[a] <= SAT_MIN;
        s3_f_q[a] <= SAT_MAX;
      end else if (t_lo[a] > t_hi[a]) begin
        s3_n_q[a] <= t_hi[a];
        s3_f_q[a] <= t_lo[a];
      end else begin
        s3_n_q[a] <= t_lo[a];
        s3_f_q[a] <= t_hi[a];
      end
    end
  end

  // Stage 4: the intervals meet exactly when every near end is at most every
  // far end of the other axes, so the running intersection reduces to six
  // independent compares.
  logic meet_d;
  logic done_q;
  logic hit_q;

  always_comb begin
    meet_d = 1'b1;
    for (int i = 0; i < NUM_AXES; i++) begin
      for (int j = 0; j < NUM_AXES; j++) begin
        if (i != j && s3_n_q[i] > s3_f_q[j]) begin
          meet_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q <= s3_ok_q && meet_d;
  end

  assign done_o = done_q;
  assign hit_o  = hit_q;

  // Every accepted ray produces its result after the fixed latency.
  a_latency_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##PIPE_LAT done_o)
    else $error("accepted ray produced no result at the expected cycle");

  // No result appears without a ray accepted at the matching cycle.
  a_latency_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, PIPE_LAT))
    else $error("result without a matching accepted ray");

  // All six dividers stay in lockstep.
  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lo_v[0] |-> (hi_v[0] && lo_v[1] && hi_v[1] && lo_v[2] && hi_v[2]))
    else $error("divider lanes out of step");

endmodule
